// ===== design/sync_frame_xor_deframer_top_macros.svh =====
// Assertion helpers shared by the deframer modules.
`ifndef SYNC_FRAME_XOR_DEFRAMER_TOP_MACROS_SVH
`define SYNC_FRAME_XOR_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SFXD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfxd check failed in the same cycle");
`define SFXD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfxd check failed in the following cycle");
`else
`define SFXD_ASSERT_SAME(lbl, ante, cons)
`define SFXD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/sfxd_pkg.sv =====
package sfxd_pkg;

  localparam int DEF_FRAME_BYTES = 121;
  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 64;
  localparam int WIDX_W          = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 8;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [WIDX_W-1:0]     widx_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_SYNC_FIRST  = 1'b0;
  localparam cfg_idx_t CFG_SYNC_SECOND = 1'b1;

  localparam byte_t SYNC_FIRST_RST  = 8'hAA;
  localparam byte_t SYNC_SECOND_RST = 8'hBB;

endpackage

// ===== design/sfxd_in_if.sv =====
interface sfxd_in_if;
  import sfxd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/sfxd_out_if.sv =====
interface sfxd_out_if;
  import sfxd_pkg::*;

  logic  valid;
  logic  ready;
  word_t payload_word;
  widx_t word_index;
  logic  last_word;

  modport source (output valid, output payload_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input payload_word, input word_index, input last_word,
                output ready);
endinterface

// ===== design/sfxd_window.sv =====
`include "sync_frame_xor_deframer_top_macros.svh"

module sfxd_window #(
  parameter int FRAME_BYTES = sfxd_pkg::DEF_FRAME_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  sfxd_in_if.sink         in_ch,
  input  sfxd_pkg::byte_t sync_first,
  input  sfxd_pkg::byte_t sync_second,
  input  logic            emit_busy,
  output logic            frame_load,
  output sfxd_pkg::byte_t payload [FRAME_BYTES-3]
);
  import sfxd_pkg::*;

  localparam int PAY = FRAME_BYTES - 3;
  localparam int FCW = $clog2(FRAME_BYTES);

  byte_t          s1_byte_r;
  logic           s1_valid_r, s1_valid_nxt;
  byte_t          win_r [FRAME_BYTES];
  logic [FCW-1:0] fill_r, fill_nxt;
  byte_t          xor_r, xor_nxt;

  logic  full;
  logic  adv;
  logic  match;
  byte_t x_new;
  byte_t w0, w1;

  assign full  = (fill_r == FCW'(FRAME_BYTES - 1));
  assign x_new = xor_r ^ s1_byte_r;
  assign w0    = win_r[1];
  assign w1    = win_r[2];
  assign match = (w0 == sync_first) && (w1 == sync_second) && ((x_new ^ w0 ^ w1) == '0);

  // A completing window waits while the previous frame is still being sent.
  assign adv         = s1_valid_r && !(full && emit_busy);
  assign in_ch.ready = !s1_valid_r || adv;
  assign frame_load  = adv && full && match;

  always_comb begin
    for (int p = 0; p < PAY; p++) begin
      payload[p] = win_r[3 + p];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    fill_nxt     = fill_r;
    xor_nxt      = xor_r;
    if (in_ch.valid && in_ch.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (adv) begin
      if (!full) begin
        fill_nxt = fill_r + 1'b1;
        xor_nxt  = x_new;
      end else if (match) begin
        fill_nxt = '0;
        xor_nxt  = '0;
      end else begin
        fill_nxt = FCW'(FRAME_BYTES - 1);
        xor_nxt  = x_new ^ w0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fill_r     <= '0;
      xor_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      fill_r     <= fill_nxt;
      xor_r      <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (adv) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[FRAME_BYTES - 1] <= s1_byte_r;
    end
  end

  `SFXD_ASSERT_NEXT(a_accept_empties_window, frame_load, fill_r == '0)
  `SFXD_ASSERT_SAME(a_fill_in_range, 1'b1, fill_r <= FCW'(FRAME_BYTES - 1))
  `SFXD_ASSERT_SAME(a_stall_holds_byte, !in_ch.ready, s1_valid_r && full && emit_busy)

endmodule

// ===== design/sfxd_emit.sv =====
`include "sync_frame_xor_deframer_top_macros.svh"

module sfxd_emit #(
  parameter int FRAME_BYTES = sfxd_pkg::DEF_FRAME_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            frame_load,
  input  sfxd_pkg::byte_t payload [FRAME_BYTES-3],
  output logic            emit_busy,
  sfxd_out_if.source      out_ch
);
  import sfxd_pkg::*;

  localparam int PAY    = FRAME_BYTES - 3;
  localparam int WORDS  = (PAY + 7) / 8;
  localparam int WCW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WSLOTS = 1 << WCW;

  byte_t          pbuf_r [PAY];
  logic           valid_r, valid_nxt;
  logic [WCW-1:0] wcnt_r, wcnt_nxt;
  word_t          words [WSLOTS];
  logic           last;
  logic           fire;

  always_comb begin
    for (int k = 0; k < WSLOTS; k++) begin
      for (int b = 0; b < 8; b++) begin
        if (k * 8 + b < PAY) begin
          words[k][8*b +: 8] = pbuf_r[k * 8 + b];
        end else begin
          words[k][8*b +: 8] = '0;
        end
      end
    end
  end

  assign last                = (wcnt_r == WCW'(WORDS - 1));
  assign fire                = valid_r && out_ch.ready;
  assign emit_busy           = valid_r;
  assign out_ch.valid        = valid_r;
  assign out_ch.payload_word = words[wcnt_r];
  assign out_ch.word_index   = WIDX_W'(wcnt_r);
  assign out_ch.last_word    = last;

  always_comb begin
    valid_nxt = valid_r;
    wcnt_nxt  = wcnt_r;
    if (frame_load) begin
      valid_nxt = 1'b1;
      wcnt_nxt  = '0;
    end else if (fire) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        wcnt_nxt = wcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wcnt_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_load) begin
      pbuf_r <= payload;
    end
  end

  `SFXD_ASSERT_SAME(a_load_when_idle, frame_load, !valid_r)
  `SFXD_ASSERT_NEXT(a_more_words_follow, valid_r && out_ch.ready && !last, valid_r)
  `SFXD_ASSERT_NEXT(a_frame_done, valid_r && out_ch.ready && last && !frame_load, !valid_r)

endmodule

// ===== design/sync_frame_xor_deframer_top.sv =====
// Channel    Dir  Beat contents
// in_ch      in   rx_byte: one byte of the received stream
// out_ch     out  payload_word, word_index, last_word: one payload word of a frame
// cfg_*      in   cfg_index selects sync_first or sync_second, cfg_data is the value
//
// One byte is taken per cycle; it sits in the input register, then joins the window.
// The first word of an accepted frame is offered right after the edge at which its check
// byte joins the window, then one word per cycle while out_ch is ready.
// The input stalls only when a window completes while the previous frame is still sent.
// Reset is synchronous and active low and empties the window and the word buffer at once.
// After reset the sync bytes are 0xAA and 0xBB.
module sync_frame_xor_deframer_top #(
  parameter int FRAME_BYTES = sfxd_pkg::DEF_FRAME_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  sfxd_in_if.sink             in_ch,
  sfxd_out_if.source          out_ch,
  input  logic                cfg_we,
  input  sfxd_pkg::cfg_idx_t  cfg_index,
  input  sfxd_pkg::cfg_data_t cfg_data
);
  import sfxd_pkg::*;

  byte_t sync_first_r;
  byte_t sync_second_r;
  logic  emit_busy;
  logic  frame_load;
  byte_t payload [FRAME_BYTES-3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfxd_window #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .emit_busy   (emit_busy),
    .frame_load  (frame_load),
    .payload     (payload)
  );

  sfxd_emit #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_load (frame_load),
    .payload    (payload),
    .emit_busy  (emit_busy),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/tb_sync_frame_xor_deframer_top.sv =====
`timescale 1ns / 100ps
module tb_sync_frame_xor_deframer_top;
  import sfxd_pkg::*;

  localparam int FRAME_BYTES   = DEF_FRAME_BYTES;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - 3;
  localparam int PAYLOAD_WORDS = (PAYLOAD_BYTES + 7) / 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 4;

  typedef enum {FRM_GOOD, FRM_BAD_CHECK, FRM_BAD_SYNC, FRM_CUT} frame_kind_e;
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct {
    word_t payload_word;
    widx_t word_index;
    logic  last_word;
  } payload_beat_t;

  class deframe_scoreboard;
    byte_t         sync_first;
    byte_t         sync_second;
    byte_t         window[$];
    byte_t         window_xor;
    payload_beat_t expected_words[$];
    int            errors;
    int            frames_found;

    function void clear();
      sync_first   = SYNC_FIRST_RST;
      sync_second  = SYNC_SECOND_RST;
      window.delete();
      window_xor   = '0;
      expected_words.delete();
      errors       = 0;
      frames_found = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t val);
      if (idx == CFG_SYNC_FIRST) begin
        sync_first = val;
      end else if (idx == CFG_SYNC_SECOND) begin
        sync_second = val;
      end
    endfunction

    // The check byte matches the payload XOR exactly when the XOR of the
    // whole window, sync bytes excluded, is zero.
    function void note_byte(byte_t b);
      payload_beat_t beat;
      byte_t         dropped;
      window.push_back(b);
      window_xor ^= b;
      if (window.size() < FRAME_BYTES) return;
      if (window[0] == sync_first && window[1] == sync_second &&
          (window_xor ^ window[0] ^ window[1]) == 8'h00) begin
        for (int k = 0; k < PAYLOAD_WORDS; k++) begin
          beat.payload_word = '0;
          for (int j = 0; j < 8; j++) begin
            if (k * 8 + j < PAYLOAD_BYTES) beat.payload_word[8*j +: 8] = window[2 + k * 8 + j];
          end
          beat.word_index = widx_t'(k);
          beat.last_word  = (k == PAYLOAD_WORDS - 1);
          expected_words.push_back(beat);
        end
        window.delete();
        window_xor = '0;
        frames_found++;
      end else begin
        dropped = window.pop_front();
        window_xor ^= dropped;
      end
    endfunction

    function void check_word(word_t w, widx_t idx, logic is_last);
      payload_beat_t exp_beat;
      if (expected_words.size() == 0) begin
        $error("unexpected beat: payload_word %h word_index %0d last_word %0b", w, idx, is_last);
        errors++;
        return;
      end
      exp_beat = expected_words.pop_front();
      if (w !== exp_beat.payload_word) begin
        $error("payload_word: expected %h, actual %h", exp_beat.payload_word, w);
        errors++;
      end
      if (idx !== exp_beat.word_index) begin
        $error("word_index: expected %0d, actual %0d", exp_beat.word_index, idx);
        errors++;
      end
      if (is_last !== exp_beat.last_word) begin
        $error("last_word: expected %0b, actual %0b", exp_beat.last_word, is_last);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  sfxd_in_if  in_ch ();
  sfxd_out_if out_ch ();

  sync_frame_xor_deframer_top #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  deframe_scoreboard sb;
  int                in_idle_pct  = 15;
  int                out_idle_pct = 15;
  int                bytes_sent   = 0;
  int                cycle_count  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_word(out_ch.payload_word, out_ch.word_index, out_ch.last_word);
    end
  end

  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_t s1, input byte_t s2, input frame_kind_e kind,
                            input fill_e fill);
    byte_t frame_bytes[$];
    byte_t check_byte;
    byte_t p;
    int    n_send;
    int    pos;
    check_byte = '0;
    frame_bytes.push_back(s1);
    frame_bytes.push_back(s2);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      case (fill)
        FILL_ZERO: p = 8'h00;
        FILL_ONES: p = 8'hFF;
        default:   p = byte_t'($urandom);
      endcase
      frame_bytes.push_back(p);
      check_byte ^= p;
    end
    frame_bytes.push_back(check_byte);
    n_send = FRAME_BYTES;
    case (kind)
      FRM_BAD_CHECK: begin
        frame_bytes[FRAME_BYTES-1] ^= byte_t'($urandom_range(1, 255));
      end
      FRM_BAD_SYNC: begin
        pos = $urandom_range(1);
        frame_bytes[pos] ^= byte_t'(8'h01 << $urandom_range(7));
      end
      FRM_CUT: begin
        n_send = $urandom_range(2, FRAME_BYTES - 2);
      end
      default: ;
    endcase
    for (int i = 0; i < n_send; i++) send_byte(frame_bytes[i]);
  endtask

  // Noise leans on the sync values so that false starts are common.
  task automatic send_noise(input int n, input byte_t s1, input byte_t s2);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(3);
      if (pick == 0) begin
        send_byte(s1);
      end else if (pick == 1) begin
        send_byte(s2);
      end else begin
        send_byte(byte_t'($urandom));
      end
    end
  endtask

  task automatic write_syncs(input byte_t s1, input byte_t s2);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_data  <= s1;
    @(posedge clk);
    sb.write_reg(CFG_SYNC_FIRST, s1);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_data  <= s2;
    @(posedge clk);
    sb.write_reg(CFG_SYNC_SECOND, s2);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input byte_t s1, input byte_t s2, input int min_bytes);
    int start_bytes;
    int start_frames;
    int pick;
    start_bytes  = bytes_sent;
    start_frames = sb.frames_found;
    while (bytes_sent - start_bytes < min_bytes || sb.frames_found == start_frames) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame(s1, s2, FRM_GOOD, FILL_RANDOM);
      end else if (pick < 70) begin
        send_frame(s1, s2, FRM_BAD_CHECK, FILL_RANDOM);
      end else if (pick < 76) begin
        send_frame(s1, s2, FRM_BAD_SYNC, FILL_RANDOM);
      end else if (pick < 84) begin
        send_frame(s1, s2, FRM_CUT, FILL_RANDOM);
      end else begin
        send_noise($urandom_range(1, 12), s1, s2);
      end
    end
    drain();
  endtask

  initial begin
    byte_t rnd_first;
    byte_t rnd_second;
    sb = new();
    sb.clear();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SYNC_FIRST;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The window stays short of a frame here, so these beats produce nothing.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    send_frame(SYNC_FIRST_RST, SYNC_SECOND_RST, FRM_GOOD, FILL_ONES);
    send_frame(SYNC_FIRST_RST, SYNC_SECOND_RST, FRM_GOOD, FILL_ZERO);
    drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_syncs(8'h00, 8'hFF);
    run_phase(8'h00, 8'hFF, 0);
    in_idle_pct  = 15;
    out_idle_pct = 15;

    rnd_first  = byte_t'($urandom);
    rnd_second = byte_t'($urandom);
    write_syncs(rnd_first, rnd_second);
    run_phase(rnd_first, rnd_second, 0);

    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sfxd_pkg.sv
design/sfxd_in_if.sv
design/sfxd_out_if.sv
design/sfxd_window.sv
design/sfxd_emit.sv
design/sync_frame_xor_deframer_top.sv
tb/tb_sync_frame_xor_deframer_top.sv
